/* sv/wle_pkg.sv */
// ----------------------------------------------------------------------------
// Wiki link extractor package
// Shared types and constants for the link extractor front end, queue and
// result serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package wle_pkg;

  // Saturation bound of the template nesting counter.
  localparam int unsigned TemplateDepthMax = 255;
  localparam int unsigned DepthW = $clog2(TemplateDepthMax + 1);

  // Result queue between the front end and the serializer.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw = $clog2(FifoDepth);

  localparam logic [7:0] ChOpenSq    = 8'h5B;  // '['
  localparam logic [7:0] ChCloseSq   = 8'h5D;  // ']'
  localparam logic [7:0] ChOpenBrace = 8'h7B;  // '{'
  localparam logic [7:0] ChCloseBr   = 8'h7D;  // '}'
  localparam logic [7:0] ChColon     = 8'h3A;  // ':'
  localparam logic [7:0] ChPipe      = 8'h7C;  // '|'
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChLowerZ    = 8'h7A;
  localparam logic [7:0] CaseDelta   = 8'h20;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_TMPL = 2'd1,
    MODE_LINK = 2'd2
  } mode_e;

  // HALF_CLOSE is a pending '}' in template mode or a held ']' in link mode.
  typedef enum logic [1:0] {
    HALF_NONE       = 2'd0,
    HALF_SQ         = 2'd1,
    HALF_OPEN_BRACE = 2'd2,
    HALF_CLOSE      = 2'd3
  } half_e;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
  } res_t;

  // One queue entry holds all results of one text byte.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic  push;
    mode_e mode;
  } front_stat_t;

endpackage

`default_nettype wire

/* sv/wle_front.sv */
// ----------------------------------------------------------------------------
// Link extractor front end
// Tracks the scan state one accepted text byte per cycle and forms the
// results of each byte as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module wle_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [7:0]           text_byte_i,
  input  wire logic                 article_end_i,
  output wle_pkg::entry_t           entry_o,
  output wle_pkg::front_stat_t      stat_o
);
  import wle_pkg::*;

  mode_e             mode_q, mode_d;
  half_e             half_q, half_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              colon_q, colon_d;
  logic              pipe_q, pipe_d;
  logic              first_q, first_d;

  logic [7:0] b;
  logic       close_hit;
  logic       opens_link;
  logic       is_sq_close;
  logic [1:0] n;

  function automatic logic [7:0] upcase(input logic [7:0] c, input logic first);
    if (first && (c >= ChLowerA) && (c <= ChLowerZ)) begin
      return c - CaseDelta;
    end
    return c;
  endfunction

  assign b           = text_byte_i;
  assign is_sq_close = (b == ChCloseSq);
  assign close_hit   = (mode_q == MODE_LINK) && (half_q == HALF_CLOSE) && is_sq_close;
  assign opens_link  = (mode_q == MODE_TEXT) && (half_q == HALF_SQ) && (b == ChOpenSq);

  // Next state.
  always_comb begin
    mode_d  = mode_q;
    half_d  = half_q;
    depth_d = depth_q;
    colon_d = colon_q;
    pipe_d  = pipe_q;
    first_d = first_q;
    unique case (mode_q)
      MODE_TEXT: begin
        if (opens_link) begin
          mode_d  = MODE_LINK;
          half_d  = HALF_NONE;
          colon_d = 1'b0;
          pipe_d  = 1'b0;
          first_d = 1'b1;
        end else if ((half_q == HALF_OPEN_BRACE) && (b == ChOpenBrace)) begin
          mode_d  = MODE_TMPL;
          half_d  = HALF_NONE;
          depth_d = DepthW'(1);
        end else if (b == ChOpenSq) begin
          half_d = HALF_SQ;
        end else if (b == ChOpenBrace) begin
          half_d = HALF_OPEN_BRACE;
        end else begin
          half_d = HALF_NONE;
        end
      end
      MODE_TMPL: begin
        if ((half_q == HALF_OPEN_BRACE) && (b == ChOpenBrace)) begin
          if (depth_q != DepthW'(TemplateDepthMax)) begin
            depth_d = depth_q + DepthW'(1);
          end
          half_d = HALF_NONE;
        end else if ((half_q == HALF_CLOSE) && (b == ChCloseBr)) begin
          if (depth_q != '0) begin
            depth_d = depth_q - DepthW'(1);
          end
          half_d = HALF_NONE;
          if (depth_q <= DepthW'(1)) begin
            mode_d = MODE_TEXT;
          end
        end else if (b == ChOpenBrace) begin
          half_d = HALF_OPEN_BRACE;
        end else if (b == ChCloseBr) begin
          half_d = HALF_CLOSE;
        end else begin
          half_d = HALF_NONE;
        end
      end
      MODE_LINK: begin
        if (close_hit) begin
          mode_d = MODE_TEXT;
          half_d = HALF_NONE;
        end else begin
          // A held ']' that does not close is a plain byte unless a pipe was seen.
          if (half_q == HALF_CLOSE) begin
            first_d = 1'b0;
            half_d  = HALF_NONE;
          end
          if (is_sq_close) begin
            half_d  = HALF_CLOSE;
            first_d = 1'b0;
          end else begin
            if (b == ChColon) begin
              colon_d = 1'b1;
            end
            if (b == ChPipe) begin
              pipe_d = 1'b1;
            end
            first_d = 1'b0;
          end
        end
      end
      default: begin
        mode_d = MODE_TEXT;
        half_d = HALF_NONE;
      end
    endcase
    if (article_end_i) begin
      mode_d  = MODE_TEXT;
      half_d  = HALF_NONE;
      depth_d = '0;
      colon_d = 1'b0;
      pipe_d  = 1'b0;
      first_d = 1'b0;
    end
  end

  // Results of the current byte.
  always_comb begin
    n                 = 2'd0;
    entry_o.r0.kind     = KIND_BYTE;
    entry_o.r0.out_byte = '0;
    entry_o.r1.kind     = KIND_BYTE;
    entry_o.r1.out_byte = '0;
    if (article_end_i && (((mode_q == MODE_LINK) && !close_hit) || opens_link)) begin
      // The article ends inside a link: a lone reject replaces any bytes.
      n               = 2'd1;
      entry_o.r0.kind = KIND_REJECT;
    end else if (mode_q == MODE_LINK) begin
      if (close_hit) begin
        n               = 2'd1;
        entry_o.r0.kind = colon_q ? KIND_REJECT : KIND_ACCEPT;
      end else begin
        if ((half_q == HALF_CLOSE) && !pipe_q) begin
          n                   = 2'd1;
          entry_o.r0.out_byte = ChCloseSq;
        end
        if (!is_sq_close && (b != ChPipe) && !pipe_q) begin
          if (n == 2'd0) begin
            entry_o.r0.out_byte = upcase(b, first_q);
          end else begin
            entry_o.r1.out_byte = upcase(b, first_q);
          end
          n = n + 2'd1;
        end
      end
    end
    entry_o.two = (n == 2'd2);
  end

  assign stat_o.push = accept_i && (n != 2'd0);
  assign stat_o.mode = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TEXT;
      half_q  <= HALF_NONE;
      depth_q <= '0;
      colon_q <= 1'b0;
      pipe_q  <= 1'b0;
      first_q <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      half_q  <= half_d;
      depth_q <= depth_d;
      colon_q <= colon_d;
      pipe_q  <= pipe_d;
      first_q <= first_d;
    end
  end

endmodule

`default_nettype wire

/* sv/wle_fifo.sv */
// ----------------------------------------------------------------------------
// Link extractor result queue
// Short first-in first-out queue of per-byte result entries between the
// front end and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module wle_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire wle_pkg::entry_t  entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output wle_pkg::entry_t       entry_o,
  output logic                  empty_o
);
  import wle_pkg::*;

  entry_t            mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (FifoAw+1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoAw'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoAw'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (FifoAw+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (FifoAw+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/wle_back.sv */
// ----------------------------------------------------------------------------
// Link extractor result serializer
// Takes queue entries and gives out their results one per transaction from
// an output register, marking the final result of each text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wle_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire wle_pkg::entry_t  entry_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            kind_o,
  output logic [7:0]            out_byte_o,
  output logic                  last_o,
  output logic                  pend_o
);
  import wle_pkg::*;

  logic  valid_q;
  logic  pend_q;
  res_t  cur_q, cur_d;
  res_t  second_q;
  logic  last_q, last_d;
  logic  slot_free;
  logic  load;

  assign slot_free = !valid_q || out_ready_i;
  // The second result of an entry goes out before the next entry is taken.
  assign pop_o     = slot_free && !pend_q && !empty_i;
  assign load      = slot_free && (pend_q || !empty_i);

  always_comb begin
    if (pend_q) begin
      cur_d  = second_q;
      last_d = 1'b1;
    end else begin
      cur_d  = entry_i.r0;
      last_d = !entry_i.two;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (slot_free) begin
      valid_q <= load;
      pend_q  <= pop_o && entry_i.two;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q  <= cur_d;
      last_q <= last_d;
    end
    if (pop_o) begin
      second_q <= entry_i.r1;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = cur_q.kind;
  assign out_byte_o  = cur_q.out_byte;
  assign last_o      = last_q;
  assign pend_o      = pend_q;

endmodule

`default_nettype wire

/* sv/wiki_link_extractor.sv */
// A result passes through the result queue and then the output register.
// Throughput: one text byte per cycle while the queue has room; results leave at one
// per cycle while out_ready_i is high; the result queue absorbs bytes with two results.
// Input ready drops only when the four-entry result queue is full.
// Reset (rst_ni low, asynchronous) returns the scanner to text mode and empties the queue
// and the output register.
// ----------------------------------------------------------------------------
// Wiki link extractor
// Streams article bytes, skips nested templates and gives out link target
// bytes followed by an accept or reject verdict for each link.
// ----------------------------------------------------------------------------
`default_nettype none

module wiki_link_extractor (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       article_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);
  import wle_pkg::*;

  entry_t      front_entry;
  entry_t      fifo_entry;
  front_stat_t front_stat;
  logic        fifo_full;
  logic        fifo_empty;
  logic        fifo_pop;
  logic        accept;
  logic        back_pend;

  assign in_ready_o = !fifo_full;
  assign accept     = in_valid_i && in_ready_o;

  wle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_byte_i),
    .article_end_i (article_end_i),
    .entry_o       (front_entry),
    .stat_o        (front_stat)
  );

  wle_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_stat.push),
    .entry_i (front_entry),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .entry_o (fifo_entry),
    .empty_o (fifo_empty)
  );

  wle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (fifo_entry),
    .empty_i     (fifo_empty),
    .pop_o       (fifo_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .pend_o      (back_pend)
  );

  // A verdict is always the final result of its text byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != KIND_BYTE)) |-> last_o)
    else $error("link verdict not marked last");

  // A held second result implies the first one is still on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_pend |-> out_valid_o)
    else $error("second result pending without a valid output");

  // The queue is never written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(front_stat.push && fifo_full))
    else $error("result queue overflow");

  // Scanner state returns to text mode after the last byte of an article.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && article_end_i) |=> (front_stat.mode == MODE_TEXT))
    else $error("scan state not reset at article end");

endmodule

`default_nettype wire

/* bench/link_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link extractor checker
// Watches both channels of the wiki link extractor. It predicts the link
// target bytes and the link verdicts for every accepted text byte, then
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------

module link_checker
  import wle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] text_byte_i,
  input  logic       article_end_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [1:0] kind_i,
  input  logic [7:0] out_byte_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         target_bytes_o,
  output int         accepted_o,
  output int         rejected_o
);

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       last;
  } link_out_t;

  mode_e             scan_st;
  half_e             half_st;
  logic [DepthW-1:0] tmpl_depth;
  logic              link_colon;
  logic              link_piped;
  logic              link_first;

  link_out_t expected_link_q[$];
  link_out_t step_q[$];

  int fails = 0;
  int n_target = 0;
  int n_accept = 0;
  int n_reject = 0;

  assign fail_count_o   = fails;
  assign target_bytes_o = n_target;
  assign accepted_o     = n_accept;
  assign rejected_o     = n_reject;

  task automatic clear_scan();
    scan_st    = MODE_TEXT;
    half_st    = HALF_NONE;
    tmpl_depth = '0;
    link_colon = 1'b0;
    link_piped = 1'b0;
    link_first = 1'b0;
  endtask

  task automatic add_result(input link_out_t r);
    step_q = {step_q, r};
  endtask

  // Only bytes before the first pipe are given out; the first one is capitalized.
  task automatic emit_target(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (!link_piped) begin
      if (link_first && c >= ChLowerA && c <= ChLowerZ) begin
        v = c - CaseDelta;
      end
      add_result('{kind: KIND_BYTE, out_byte: v, last: 1'b0});
    end
    link_first = 1'b0;
  endtask

  task automatic scan_text_byte(input logic [7:0] b, input logic fin);
    logic closed;
    closed = 1'b0;
    step_q.delete();
    case (scan_st)
      MODE_TEXT: begin
        if (half_st == HALF_SQ && b == ChOpenSq) begin
          scan_st    = MODE_LINK;
          half_st    = HALF_NONE;
          link_colon = 1'b0;
          link_piped = 1'b0;
          link_first = 1'b1;
        end else if (half_st == HALF_OPEN_BRACE && b == ChOpenBrace) begin
          scan_st    = MODE_TMPL;
          half_st    = HALF_NONE;
          tmpl_depth = DepthW'(1);
        end else if (b == ChOpenSq) begin
          half_st = HALF_SQ;
        end else if (b == ChOpenBrace) begin
          half_st = HALF_OPEN_BRACE;
        end else begin
          half_st = HALF_NONE;
        end
      end
      MODE_TMPL: begin
        if (half_st == HALF_OPEN_BRACE && b == ChOpenBrace) begin
          if (tmpl_depth < TemplateDepthMax) tmpl_depth = tmpl_depth + 1'b1;
          half_st = HALF_NONE;
        end else if (half_st == HALF_CLOSE && b == ChCloseBr) begin
          if (tmpl_depth > 0) tmpl_depth = tmpl_depth - 1'b1;
          half_st = HALF_NONE;
          if (tmpl_depth == 0) scan_st = MODE_TEXT;
        end else if (b == ChOpenBrace) begin
          half_st = HALF_OPEN_BRACE;
        end else if (b == ChCloseBr) begin
          half_st = HALF_CLOSE;
        end else begin
          half_st = HALF_NONE;
        end
      end
      default: begin
        if (half_st == HALF_CLOSE && b == ChCloseSq) begin
          add_result('{kind: link_colon ? KIND_REJECT : KIND_ACCEPT,
                       out_byte: 8'h00, last: 1'b0});
          scan_st = MODE_TEXT;
          half_st = HALF_NONE;
          closed  = 1'b1;
        end else begin
          // A held bracket that did not close the link is ordinary target text.
          if (half_st == HALF_CLOSE) begin
            emit_target(ChCloseSq);
            half_st = HALF_NONE;
          end
          if (b == ChCloseSq) begin
            half_st    = HALF_CLOSE;
            link_first = 1'b0;
          end else begin
            if (b == ChColon) link_colon = 1'b1;
            if (b == ChPipe) begin
              link_piped = 1'b1;
              link_first = 1'b0;
            end else begin
              emit_target(b);
            end
          end
        end
      end
    endcase

    if (fin) begin
      if (scan_st == MODE_LINK && !closed) begin
        step_q.delete();
        add_result('{kind: KIND_REJECT, out_byte: 8'h00, last: 1'b0});
      end
      clear_scan();
    end

    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].last = 1'b1;
    end
    expected_link_q = {expected_link_q, step_q};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    link_out_t want;
    if (!rst_ni) begin
      clear_scan();
      expected_link_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) scan_text_byte(text_byte_i, article_end_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_link_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: expected none, got kind %0d byte 8'h%02h last %0b",
                   $time, kind_i, out_byte_i, last_i);
        end else begin
          want = expected_link_q.pop_front();
          if (kind_i !== want.kind || out_byte_i !== want.out_byte || last_i !== want.last) begin
            fails++;
            $display("%0t: result mismatch: expected kind %0d byte 8'h%02h last %0b, %s",
                     $time, want.kind, want.out_byte, want.last,
                     $sformatf("got kind %0d byte 8'h%02h last %0b",
                               kind_i, out_byte_i, last_i));
          end
        end
        case (kind_i)
          KIND_BYTE:   n_target++;
          KIND_ACCEPT: n_accept++;
          default:     n_reject++;
        endcase
      end
    end
    pending_o <= expected_link_q.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wiki link extractor testbench
// Feeds directed and random articles made of links, nested templates and
// noise through the extractor under several sender and receiver idling
// patterns; the checker compares every result against its prediction.
// ----------------------------------------------------------------------------

module tb;
  import wle_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int PhaseBytes    = 205;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [7:0] text_byte_i   = 8'h00;
  logic       article_end_i = 1'b0;
  logic       out_ready_i   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic       last_o;

  int fails;
  int pending;
  int n_target;
  int n_accept;
  int n_reject;

  int idle_pct  = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int articles_sent = 0;
  int quiet_cycles = 0;

  logic [7:0] article_q[$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  wiki_link_extractor uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .article_end_i(article_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

  link_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .article_end_i (article_end_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_i        (kind_o),
    .out_byte_i    (out_byte_o),
    .last_i        (last_o),
    .fail_count_o  (fails),
    .pending_o     (pending),
    .target_bytes_o(n_target),
    .accepted_o    (n_accept),
    .rejected_o    (n_reject)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // The run ends if no transaction happens on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: timeout with %0d results outstanding", $time, pending);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    article_end_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_article();
    foreach (article_q[i]) send_byte(article_q[i], i == article_q.size() - 1);
    article_q.delete();
    articles_sent++;
  endtask

  task automatic add_byte(input logic [7:0] c);
    article_q = {article_q, c};
  endtask

  task automatic put_str(input string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  function automatic logic [7:0] text_char();
    case ($urandom_range(9))
      0:       return ChOpenSq;
      1:       return ChCloseSq;
      2:       return ChOpenBrace;
      3:       return ChCloseBr;
      4:       return ChColon;
      5:       return ChPipe;
      6, 7:    return 8'($urandom_range(ChLowerZ, ChLowerA));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] target_char();
    case ($urandom_range(11))
      0:       return ChColon;
      1:       return ChCloseSq;
      2:       return 8'($urandom_range(255));
      3, 4:    return 8'($urandom_range(8'h5A, 8'h41));
      default: return 8'($urandom_range(ChLowerZ, ChLowerA));
    endcase
  endfunction

  // Most links are well formed; one in ten is left open.
  task automatic rand_link();
    put_str("[[");
    repeat ($urandom_range(6)) add_byte(target_char());
    if ($urandom_range(3) == 0) begin
      add_byte(ChPipe);
      repeat ($urandom_range(4)) add_byte(target_char());
    end
    if ($urandom_range(9) != 0) put_str("]]");
  endtask

  task automatic rand_template(input int level);
    put_str("{{");
    repeat ($urandom_range(4)) begin
      case ($urandom_range(5))
        0:       if (level < 3) rand_template(level + 1);
        1:       rand_link();
        default: add_byte(text_char());
      endcase
    end
    if ($urandom_range(19) != 0) put_str("}}");
  endtask

  task automatic rand_article();
    repeat ($urandom_range(6, 1)) begin
      case ($urandom_range(9))
        0, 1, 2: repeat ($urandom_range(5, 1)) add_byte(text_char());
        3, 4:    rand_template(0);
        default: rand_link();
      endcase
    end
    send_article();
  endtask

  initial begin : stimulus
    int base;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Triple bracket, held bracket that does not close, capitalized first byte,
    // extreme byte values, colon after the pipe, a template, and an article
    // that ends on the byte that opens a link.
    put_str("[[[z]x]]");
    put_str("[[q");
    add_byte(8'h00);
    add_byte(8'hFF);
    put_str("|:]]");
    put_str("{{x}}");
    put_str("[[");
    send_article();

    // Deep nesting: exactly the matching number of closes leaves the template,
    // so the following link must show up.
    repeat (12) put_str("{{");
    repeat (12) put_str("}}");
    put_str("[[s]]");
    send_article();

    base = bytes_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      while (bytes_sent - base < (ph + 1) * PhaseBytes) rand_article();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Summary: %0d text bytes in %0d articles under four idling patterns.",
             bytes_sent, articles_sent);
    $display("Summary: %0d target bytes, %0d accepted and %0d rejected links compared.",
             n_target, n_accept, n_reject);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/wle_pkg.sv
sv/wle_front.sv
sv/wle_fifo.sv
sv/wle_back.sv
sv/wiki_link_extractor.sv
bench/link_checker.sv
bench/tb.sv
